[hdl/ripd_pkg.sv]
// Package for the RI pattern phase detector.
// Holds reset values, register indexes, slice level codes and phase helpers.
// No dependencies.
package ripd_pkg;

  localparam int RUN_BITS_DEF = 8;

  localparam int THR_W   = 15;
  localparam int LEN_W   = 8;
  localparam int PHASE_W = 3;
  localparam int NUM_ROT = 6;

  localparam logic [THR_W-1:0] THR_RESET      = 15'd100;
  localparam logic [LEN_W-1:0] LOCK_LEN_RESET = 8'd24;
  localparam logic [LEN_W-1:0] INV_LEN_RESET  = 8'd18;

  typedef enum logic [1:0] {
    REG_SLICE_THR = 2'd0,
    REG_LOCK_LEN  = 2'd1,
    REG_INV_LEN   = 2'd2,
    REG_UNUSED    = 2'd3
  } cfg_reg_t;

  typedef logic signed [1:0] level_t;

  localparam level_t LEVEL_POS  = 2'sb01;
  localparam level_t LEVEL_ZERO = 2'sb00;
  localparam level_t LEVEL_NEG  = 2'sb11;

  // (a + b) mod 6 for a, b in 0..5
  function automatic logic [PHASE_W-1:0] mod6_add(input logic [PHASE_W-1:0] a,
                                                   input logic [PHASE_W-1:0] b);
    logic [PHASE_W:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    if (sum >= 4'd6) begin
      sum = sum - 4'd6;
    end
    return sum[PHASE_W-1:0];
  endfunction

  // +++--- pattern value at position idx (0..5)
  function automatic level_t pattern_level(input logic [PHASE_W-1:0] idx);
    return (idx < 3'd3) ? LEVEL_POS : LEVEL_NEG;
  endfunction

endpackage

[hdl/ri_pattern_phase_detector_top.sv]
// RI pattern phase detector, top level: slicer, phase counter, run counters.
// Depends on ripd_pkg.
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+---------------------------------------
//  in_     | input     | in_valid / in_stall | in_sample[15:0] s, in_armed
//  out_    | output    | out_valid/out_stall | out_ri_seen, out_ri_bar_seen,
//          |           |                     | out_lock_phase[2:0], out_sliced_level
//  cfg_    | input     | cfg_valid/cfg_ready | cfg_index[1:0], cfg_data[14:0]
//
// Two register stages: input register, then slice + counter update into the
// state and the result register. One item per cycle sustained while out_stall
// is low. Synchronous active-low reset clears all detector state and loads the
// register defaults. out_stall holds the result register; the input register
// then fills and in_stall rises once it holds an item. cfg_ready is always high.
module ri_pattern_phase_detector_top
  import ripd_pkg::*;
#(
  parameter int RUN_BITS = RUN_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // item input
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic signed [15:0]   in_sample,
  input  logic                 in_armed,
  // result output
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 out_ri_seen,
  output logic                 out_ri_bar_seen,
  output logic [PHASE_W-1:0]   out_lock_phase,
  output logic signed [1:0]    out_sliced_level,
  // configuration
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [1:0]           cfg_index,
  input  logic [THR_W-1:0]     cfg_data
);

  // counters and lengths compared at a common width
  localparam int CMP_W = (RUN_BITS > LEN_W) ? RUN_BITS : LEN_W;
  localparam logic [RUN_BITS-1:0] RUN_MAX = {RUN_BITS{1'b1}};

  // configuration registers
  logic [THR_W-1:0] thr_r;
  logic [LEN_W-1:0] lock_len_r;
  logic [LEN_W-1:0] inv_len_r;

  // input register
  logic               s1_valid_r;
  logic signed [15:0] s1_sample_r;
  logic               s1_armed_r;

  // detector state
  logic [PHASE_W-1:0]  phase_r;
  logic [RUN_BITS-1:0] hyp_run_r [NUM_ROT];
  logic                locked_r;
  logic [PHASE_W-1:0]  rot_r;
  logic [RUN_BITS-1:0] inv_run_r;
  logic                inv_flag_r;

  // next-state values
  logic [RUN_BITS-1:0] hyp_run_nxt [NUM_ROT];
  logic                locked_nxt;
  logic [PHASE_W-1:0]  rot_nxt;
  logic [RUN_BITS-1:0] inv_run_nxt;
  logic                inv_flag_nxt;
  level_t              level;

  // result register
  logic                out_valid_r;
  logic                out_ri_seen_r;
  logic                out_ri_bar_seen_r;
  logic [PHASE_W-1:0]  out_lock_phase_r;
  level_t              out_level_r;

  logic adv;
  logic s2_fire;

  assign adv      = !out_valid_r || !out_stall;
  assign s2_fire  = s1_valid_r && adv;
  assign in_stall = s1_valid_r && !adv;
  assign cfg_ready = 1'b1;

  // ---------------------------------------------------------------
  // Configuration writes; an unused index is ignored
  // ---------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r      <= THR_RESET;
      lock_len_r <= LOCK_LEN_RESET;
      inv_len_r  <= INV_LEN_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_SLICE_THR: thr_r      <= cfg_data;
        REG_LOCK_LEN:  lock_len_r <= cfg_data[LEN_W-1:0];
        REG_INV_LEN:   inv_len_r  <= cfg_data[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------
  // Input register
  // ---------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_sample_r <= in_sample;
      s1_armed_r  <= in_armed;
    end
  end

  // ---------------------------------------------------------------
  // Slice and run counter update
  // ---------------------------------------------------------------
  always_comb begin
    logic signed [16:0]  s_ext;
    logic signed [16:0]  thr_pos;
    logic signed [16:0]  thr_neg;
    logic                found;
    logic [PHASE_W-1:0]  idx;
    logic [RUN_BITS-1:0] run_inc;
    logic                match;
    level_t              inv_exp;

    s_ext   = {s1_sample_r[15], s1_sample_r};
    thr_pos = $signed({2'b00, thr_r});
    thr_neg = -thr_pos;
    if (s_ext > thr_pos) begin
      level = LEVEL_POS;
    end else if (s_ext < thr_neg) begin
      level = LEVEL_NEG;
    end else begin
      level = LEVEL_ZERO;
    end

    for (int h = 0; h < NUM_ROT; h++) begin
      hyp_run_nxt[h] = hyp_run_r[h];
    end
    locked_nxt   = locked_r;
    rot_nxt      = rot_r;
    inv_run_nxt  = inv_run_r;
    inv_flag_nxt = inv_flag_r;
    found        = 1'b0;
    idx          = '0;
    run_inc      = '0;
    match        = 1'b0;
    inv_exp      = LEVEL_ZERO;

    if (s1_armed_r && !locked_r) begin
      // scan rotations in order; stop at the first one reaching the lock length
      for (int h = 0; h < NUM_ROT; h++) begin
        idx     = mod6_add(phase_r, PHASE_W'(h));
        match   = (level == pattern_level(idx));
        run_inc = (hyp_run_r[h] == RUN_MAX) ? RUN_MAX : hyp_run_r[h] + 1'b1;
        if (!found) begin
          hyp_run_nxt[h] = match ? run_inc : '0;
          if (CMP_W'(hyp_run_nxt[h]) >= CMP_W'(lock_len_r)) begin
            found      = 1'b1;
            locked_nxt = 1'b1;
            rot_nxt    = PHASE_W'(h);
          end
        end
      end
    end else if (s1_armed_r) begin
      idx     = mod6_add(phase_r, rot_r);
      inv_exp = -pattern_level(idx);
      match   = (level == inv_exp);
      run_inc = (inv_run_r == RUN_MAX) ? RUN_MAX : inv_run_r + 1'b1;
      inv_run_nxt = match ? run_inc : '0;
      if (CMP_W'(inv_run_nxt) >= CMP_W'(inv_len_r)) begin
        inv_flag_nxt = 1'b1;
      end
    end
  end

  // detector state: updated once per item leaving the input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= '0;
      locked_r   <= 1'b0;
      rot_r      <= '0;
      inv_run_r  <= '0;
      inv_flag_r <= 1'b0;
      for (int h = 0; h < NUM_ROT; h++) begin
        hyp_run_r[h] <= '0;
      end
    end else if (s2_fire) begin
      phase_r    <= mod6_add(phase_r, PHASE_W'(1));
      locked_r   <= locked_nxt;
      rot_r      <= rot_nxt;
      inv_run_r  <= inv_run_nxt;
      inv_flag_r <= inv_flag_nxt;
      for (int h = 0; h < NUM_ROT; h++) begin
        hyp_run_r[h] <= hyp_run_nxt[h];
      end
    end
  end

  // ---------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_fire) begin
      out_ri_seen_r     <= locked_nxt;
      out_ri_bar_seen_r <= inv_flag_nxt;
      out_lock_phase_r  <= rot_nxt;
      out_level_r       <= level;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_ri_seen      = out_ri_seen_r;
  assign out_ri_bar_seen  = out_ri_bar_seen_r;
  assign out_lock_phase   = out_lock_phase_r;
  assign out_sliced_level = out_level_r;

`ifndef SYNTH
  a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r < 3'd6)
    else $error("phase counter out of range");

  a_bar_needs_lock: assert property (@(posedge clk) disable iff (!rst_n)
    inv_flag_r |-> locked_r)
    else $error("RI-bar set without lock");

  a_lock_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    locked_r |=> (locked_r && $stable(rot_r)))
    else $error("lock or rotation changed after lock");

  a_result_matches_state: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_ri_seen_r == locked_r && out_lock_phase_r == rot_r
                     && out_ri_bar_seen_r == inv_flag_r))
    else $error("result register out of step with detector state");
`endif

endmodule
